// File: rtl/gbcl_pkg.sv
// Shared types, widths, register indexes and rounding helpers for the gyro bias
// calibration and lowpass core. No dependencies.
package gbcl_pkg;

	localparam int RAW_W      = 16;
	localparam int OUT_W      = 25;
	localparam int MAX_AXES   = 3;
	localparam int SUM_W      = 33;
	localparam int SQ_W       = 48;
	localparam int LEN_W      = 16;
	localparam int SL_W       = 17;
	localparam int THR_W      = 8;
	localparam int COEF_W     = 16;
	localparam int K_W        = 32;
	localparam int OPA_W      = 34;
	localparam int OPB_W      = 17;
	localparam int PROD_W     = OPA_W + OPB_W;
	localparam int RND_W      = PROD_W - 15;
	localparam int SAT_W      = RND_W + 1;
	localparam int ACC_W      = 67;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CALIB_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_S1_GAIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_S1_ENABLE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_S2_GAIN       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_S2_ENABLE     = 3'd6;

	localparam logic signed [PROD_W:0] HALF_Q16 = (PROD_W+1)'(32768);

	typedef logic signed [RAW_W-1:0]  raw_t;
	typedef logic signed [OUT_W-1:0]  rate_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	// zero length behaves as one
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		return (v == '0) ? LEN_W'(1) : v;
	endfunction

	// floor((p + 2^15) / 2^16)
	function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		t = $signed({p[PROD_W-1], p}) + HALF_Q16;
		return t[PROD_W:16];
	endfunction

	function automatic rate_t sat_out(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-OUT_W:0] top;
		top = v[SAT_W-1:OUT_W-1];
		if ((&top) || (~|top)) begin
			return v[OUT_W-1:0];
		end else if (v[SAT_W-1]) begin
			return {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(OUT_W-1){1'b1}}};
		end
	endfunction

endpackage

// File: rtl/gyro_bias_calibrate_and_lowpass_core.sv
// Gyro bias calibration, rate scaling and two-stage PT1 lowpass, top level.
// Depends on gbcl_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one raw three-axis sample per transfer.
//    in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready) gives one result per sample: scaled,
//    filtered rates with FRACTION_BITS fraction bits, or zeros with calibrating
//    set while bias calibration runs (also on the sample that completes it).
//  - Configuration channel (cfg_valid/cfg_ready) writes one register per
//    transfer; cfg_ready is always high. Write only while the block is idle.
//  - Filtering makes three passes per axis through the shared multiplier with both
//    stages on, one pass with both off. The last calibration sample adds a variance
//    check and a bit-serial division per axis for the offsets.
//  - The result sits in an output register; the next sample is accepted while
//    it waits, and the sequencer holds at its end until the register frees.
//  - Reset restores default registers, restarts calibration and clears the
//    filter states.
module gyro_bias_calibrate_and_lowpass_core #(
	parameter int AXES          = 3,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gbcl_pkg::raw_t      raw_x,
	input  gbcl_pkg::raw_t      raw_y,
	input  gbcl_pkg::raw_t      raw_z,
	output logic                out_valid,
	input  logic                out_ready,
	output gbcl_pkg::rate_t     rate_x,
	output gbcl_pkg::rate_t     rate_y,
	output gbcl_pkg::rate_t     rate_z,
	output logic                calibrating,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  gbcl_pkg::cfg_idx_t  cfg_index,
	input  gbcl_pkg::cfg_data_t cfg_data
);
	import gbcl_pkg::*;

	localparam int IN_BITS = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
	localparam int AX_W    = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int DN_W    = SUM_W + FRACTION_BITS + 2;   // divider dividend
	localparam int DC_W    = $clog2(DN_W);
	localparam logic [DN_W-1:0] Q_POS_LIM = DN_W'((1 << (OUT_W-1)) - 1);
	localparam logic [DN_W-1:0] Q_NEG_LIM = DN_W'(1 << (OUT_W-1));
	localparam logic [2:0] LAST_CHUNK = 3'd4;

	// sequencer states
	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_CAL_START = 5'd1;
	localparam logic [4:0] ST_CAL_SQ    = 5'd2;
	localparam logic [4:0] ST_CAL_ACC   = 5'd3;
	localparam logic [4:0] ST_CAL_CHECK = 5'd4;
	localparam logic [4:0] ST_MOT_T     = 5'd5;
	localparam logic [4:0] ST_MOT_K     = 5'd6;
	localparam logic [4:0] ST_MOT_KS    = 5'd7;
	localparam logic [4:0] ST_MOT_D     = 5'd8;
	localparam logic [4:0] ST_MOT_M     = 5'd9;
	localparam logic [4:0] ST_MOT_A     = 5'd10;
	localparam logic [4:0] ST_MOT_CMP   = 5'd11;
	localparam logic [4:0] ST_MOT_NEXT  = 5'd12;
	localparam logic [4:0] ST_MOT_END   = 5'd13;
	localparam logic [4:0] ST_DIV_INIT  = 5'd14;
	localparam logic [4:0] ST_DIV_STEP  = 5'd15;
	localparam logic [4:0] ST_DIV_DONE  = 5'd16;
	localparam logic [4:0] ST_RUN_D     = 5'd17;
	localparam logic [4:0] ST_RUN_SC    = 5'd18;
	localparam logic [4:0] ST_RUN_F2    = 5'd19;
	localparam logic [4:0] ST_RUN_P2    = 5'd20;
	localparam logic [4:0] ST_RUN_F1    = 5'd21;
	localparam logic [4:0] ST_RUN_P1    = 5'd22;
	localparam logic [4:0] ST_RUN_OUT   = 5'd23;
	localparam logic [4:0] ST_WAIT      = 5'd24;
	localparam logic [4:0] ST_FIN       = 5'd25;

	// configuration registers
	logic [LEN_W-1:0]  calib_length_q;
	logic [THR_W-1:0]  motion_threshold_q;
	logic [COEF_W-1:0] rate_scale_q;
	logic [COEF_W-1:0] s1_gain_q;
	logic              s1_en_q;
	logic [COEF_W-1:0] s2_gain_q;
	logic              s2_en_q;

	// sequencer
	logic [4:0]      state_q;
	logic [4:0]      ret_q;
	logic [AX_W-1:0] axis_q;
	logic [2:0]      chunk_q;
	logic [DC_W-1:0] dcnt_q;
	logic            cal_flag_q;
	logic            moved_q;

	// calibration and filter state
	logic [SL_W-1:0]          samples_left_q;
	logic                     calib_done_q;
	logic signed [SUM_W-1:0]  sum_q    [AXES];
	logic [SQ_W-1:0]          sqsum_q  [AXES];
	rate_t                    offset_q [AXES];
	rate_t                    st2_q    [AXES];
	rate_t                    st1_q    [AXES];

	// datapath
	logic signed [IN_BITS-1:0] x_q   [AXES];
	rate_t                     res_q [AXES];
	rate_t                     v_q;
	logic signed [OPA_W-1:0]   opa_q;
	logic signed [OPB_W-1:0]   opb_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [K_W-1:0]            k_q;
	logic [SQ_W-1:0]           dpos_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [DN_W-1:0]           divn_q;
	logic [LEN_W:0]            rem_q;
	logic [DN_W-1:0]           quo_q;

	// output register
	logic  out_valid_q;
	logic  calib_out_q;
	rate_t rate_q [MAX_AXES];

	raw_t  raw_in  [MAX_AXES];
	rate_t res_ext [MAX_AXES];

	assign raw_in[0] = raw_x;
	assign raw_in[1] = raw_y;
	assign raw_in[2] = raw_z;

	for (genvar g = 0; g < MAX_AXES; g++) begin : g_res
		if (g < AXES) begin : g_used
			assign res_ext[g] = res_q[g];
		end else begin : g_unused
			assign res_ext[g] = '0;
		end
	end

	// per-axis selects and combinational helpers
	logic [LEN_W-1:0]          n_eff;
	logic signed [SUM_W-1:0]   sum_sel;
	logic [SQ_W-1:0]           sq_sel;
	logic signed [IN_BITS-1:0] x_sel;
	logic signed [OPA_W-1:0]   x_wide;
	logic [SUM_W-1:0]          mag;
	logic signed [SQ_W:0]      sq_diff;
	logic                      sq_diff_pos;
	logic [COEF_W-1:0]         mot_chunk;
	logic                      mot_use_n;
	logic                      mot_neg;
	logic [5:0]                mot_sh;
	logic signed [ACC_W-1:0]   acc_term;
	logic [LEN_W+1:0]          div_r2;
	logic [LEN_W+1:0]          div_d2;
	logic                      div_ge;
	logic [LEN_W+1:0]          div_sub;
	rate_t                     off_new;
	logic signed [RND_W-1:0]   rnd_prod;
	rate_t                     scaled;
	rate_t                     st2_new;
	rate_t                     st1_new;
	logic                      axis_last;
	logic                      fin_load;

	always_comb begin
		n_eff   = eff_len(calib_length_q);
		sum_sel = sum_q[axis_q];
		sq_sel  = sqsum_q[axis_q];
		x_sel   = x_q[axis_q];
		x_wide  = OPA_W'(x_sel);
		mag     = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

		// variance test: moved when n*(ss - k) > sum^2
		sq_diff     = $signed({1'b0, sq_sel}) - $signed({{(SQ_W+1-K_W){1'b0}}, k_q});
		sq_diff_pos = !sq_diff[SQ_W] && (sq_diff != '0);

		// |sum| stays below 2^31, so two chunks cover its square
		case (chunk_q)
			3'd0: begin
				mot_chunk = dpos_q[15:0];
				mot_use_n = 1'b1;
				mot_neg   = 1'b0;
				mot_sh    = 6'd0;
			end
			3'd1: begin
				mot_chunk = dpos_q[31:16];
				mot_use_n = 1'b1;
				mot_neg   = 1'b0;
				mot_sh    = 6'd16;
			end
			3'd2: begin
				mot_chunk = dpos_q[47:32];
				mot_use_n = 1'b1;
				mot_neg   = 1'b0;
				mot_sh    = 6'd32;
			end
			3'd3: begin
				mot_chunk = mag[15:0];
				mot_use_n = 1'b0;
				mot_neg   = 1'b1;
				mot_sh    = 6'd0;
			end
			default: begin
				mot_chunk = mag[31:16];
				mot_use_n = 1'b0;
				mot_neg   = 1'b1;
				mot_sh    = 6'd16;
			end
		endcase
		acc_term = ACC_W'(prod_q) <<< mot_sh;

		// restoring division step, divisor 2n
		div_r2  = {rem_q, divn_q[DN_W-1]};
		div_d2  = {1'b0, n_eff, 1'b0};
		div_ge  = (div_r2 >= div_d2);
		div_sub = div_r2 - div_d2;

		if (sum_sel[SUM_W-1]) begin
			off_new = (quo_q > Q_NEG_LIM) ? {1'b1, {(OUT_W-1){1'b0}}}
			                              : OUT_W'(-quo_q[OUT_W-1:0]);
		end else begin
			off_new = (quo_q > Q_POS_LIM) ? {1'b0, {(OUT_W-1){1'b1}}}
			                              : OUT_W'(quo_q[OUT_W-1:0]);
		end

		rnd_prod  = rnd_q16(prod_q);
		scaled    = sat_out(SAT_W'(rnd_prod));
		st2_new   = sat_out(SAT_W'(st2_q[axis_q]) + SAT_W'(rnd_prod));
		st1_new   = sat_out(SAT_W'(st1_q[axis_q]) + SAT_W'(rnd_prod));
		axis_last = (axis_q == AX_W'(AXES-1));
		fin_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= opa_q * opb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_length_q     <= LEN_W'(10000);
			motion_threshold_q <= THR_W'(48);
			rate_scale_q       <= COEF_W'(4000);
			s1_gain_q          <= COEF_W'(11226);
			s1_en_q            <= 1'b1;
			s2_gain_q          <= COEF_W'(18839);
			s2_en_q            <= 1'b1;
			state_q            <= ST_IDLE;
			ret_q              <= ST_IDLE;
			axis_q             <= '0;
			chunk_q            <= '0;
			dcnt_q             <= '0;
			cal_flag_q         <= 1'b0;
			moved_q            <= 1'b0;
			samples_left_q     <= SL_W'(10000);
			calib_done_q       <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a]    <= '0;
				sqsum_q[a]  <= '0;
				offset_q[a] <= '0;
				st2_q[a]    <= '0;
				st1_q[a]    <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_CALIB_LENGTH: begin
						calib_length_q <= cfg_data[LEN_W-1:0];
						if (!calib_done_q) begin
							samples_left_q <= {1'b0, eff_len(cfg_data[LEN_W-1:0])};
						end
					end
					REG_MOTION_THRESH: motion_threshold_q <= cfg_data[THR_W-1:0];
					REG_RATE_SCALE:    rate_scale_q       <= cfg_data[COEF_W-1:0];
					REG_S1_GAIN:       s1_gain_q          <= cfg_data[COEF_W-1:0];
					REG_S1_ENABLE:     s1_en_q            <= cfg_data[0];
					REG_S2_GAIN:       s2_gain_q          <= cfg_data[COEF_W-1:0];
					REG_S2_ENABLE:     s2_en_q            <= cfg_data[0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						for (int a = 0; a < AXES; a++) begin
							x_q[a] <= raw_in[a][IN_BITS-1:0];
						end
						cal_flag_q <= !calib_done_q;
						axis_q     <= '0;
						state_q    <= calib_done_q ? ST_RUN_D : ST_CAL_START;
					end
				end
				ST_CAL_START: begin
					// fresh run: counter at or above the length clears the sums
					if (samples_left_q >= {1'b0, n_eff}) begin
						samples_left_q <= {1'b0, n_eff};
						for (int a = 0; a < AXES; a++) begin
							sum_q[a]   <= '0;
							sqsum_q[a] <= '0;
						end
					end
					state_q <= ST_CAL_SQ;
				end
				ST_CAL_SQ: begin
					opa_q   <= x_wide;
					opb_q   <= OPB_W'(x_sel);
					ret_q   <= ST_CAL_ACC;
					state_q <= ST_WAIT;
				end
				ST_CAL_ACC: begin
					sum_q[axis_q]   <= sum_sel + SUM_W'(x_sel);
					sqsum_q[axis_q] <= sq_sel + prod_q[SQ_W-1:0];
					if (axis_last) begin
						state_q <= ST_CAL_CHECK;
					end else begin
						axis_q  <= axis_q + AX_W'(1);
						state_q <= ST_CAL_SQ;
					end
				end
				ST_CAL_CHECK: begin
					if (samples_left_q <= SL_W'(1)) begin
						axis_q <= '0;
						if (motion_threshold_q != '0) begin
							moved_q <= 1'b0;
							state_q <= ST_MOT_T;
						end else begin
							state_q <= ST_DIV_INIT;
						end
					end else begin
						samples_left_q <= samples_left_q - SL_W'(1);
						state_q        <= ST_FIN;
					end
				end
				ST_MOT_T: begin
					opa_q   <= OPA_W'(motion_threshold_q);
					opb_q   <= OPB_W'(motion_threshold_q);
					ret_q   <= ST_MOT_K;
					state_q <= ST_WAIT;
				end
				ST_MOT_K: begin
					opa_q   <= OPA_W'(prod_q[2*THR_W-1:0]);
					opb_q   <= OPB_W'(n_eff - LEN_W'(1));
					ret_q   <= ST_MOT_KS;
					state_q <= ST_WAIT;
				end
				ST_MOT_KS: begin
					k_q     <= prod_q[K_W-1:0];
					state_q <= ST_MOT_D;
				end
				ST_MOT_D: begin
					if (sq_diff_pos) begin
						dpos_q  <= sq_diff[SQ_W-1:0];
						acc_q   <= '0;
						chunk_q <= '0;
						state_q <= ST_MOT_M;
					end else begin
						state_q <= ST_MOT_NEXT;
					end
				end
				ST_MOT_M: begin
					opa_q   <= mot_use_n ? OPA_W'(n_eff) : OPA_W'(mag);
					opb_q   <= {1'b0, mot_chunk};
					ret_q   <= ST_MOT_A;
					state_q <= ST_WAIT;
				end
				ST_MOT_A: begin
					acc_q <= mot_neg ? (acc_q - acc_term) : (acc_q + acc_term);
					if (chunk_q == LAST_CHUNK) begin
						state_q <= ST_MOT_CMP;
					end else begin
						chunk_q <= chunk_q + 3'd1;
						state_q <= ST_MOT_M;
					end
				end
				ST_MOT_CMP: begin
					if (!acc_q[ACC_W-1] && (acc_q != '0)) begin
						moved_q <= 1'b1;
					end
					state_q <= ST_MOT_NEXT;
				end
				ST_MOT_NEXT: begin
					if (axis_last) begin
						state_q <= ST_MOT_END;
					end else begin
						axis_q  <= axis_q + AX_W'(1);
						state_q <= ST_MOT_D;
					end
				end
				ST_MOT_END: begin
					axis_q <= '0;
					if (moved_q) begin
						samples_left_q <= {1'b0, n_eff};
						state_q        <= ST_FIN;
					end else begin
						state_q <= ST_DIV_INIT;
					end
				end
				ST_DIV_INIT: begin
					// round half away: (2*|sum|*2^F + n) / 2n
					divn_q  <= (DN_W'(mag) << (FRACTION_BITS + 1)) + DN_W'(n_eff);
					rem_q   <= '0;
					quo_q   <= '0;
					dcnt_q  <= DC_W'(DN_W - 1);
					state_q <= ST_DIV_STEP;
				end
				ST_DIV_STEP: begin
					rem_q  <= div_ge ? div_sub[LEN_W:0] : div_r2[LEN_W:0];
					quo_q  <= {quo_q[DN_W-2:0], div_ge};
					divn_q <= divn_q << 1;
					if (dcnt_q == '0) begin
						state_q <= ST_DIV_DONE;
					end else begin
						dcnt_q <= dcnt_q - DC_W'(1);
					end
				end
				ST_DIV_DONE: begin
					offset_q[axis_q] <= off_new;
					if (axis_last) begin
						calib_done_q   <= 1'b1;
						samples_left_q <= '0;
						state_q        <= ST_FIN;
					end else begin
						axis_q  <= axis_q + AX_W'(1);
						state_q <= ST_DIV_INIT;
					end
				end
				ST_RUN_D: begin
					opa_q   <= (x_wide <<< FRACTION_BITS) - OPA_W'(offset_q[axis_q]);
					opb_q   <= {1'b0, rate_scale_q};
					ret_q   <= ST_RUN_SC;
					state_q <= ST_WAIT;
				end
				ST_RUN_SC: begin
					v_q     <= scaled;
					state_q <= ST_RUN_F2;
				end
				ST_RUN_F2: begin
					if (s2_en_q) begin
						opa_q   <= OPA_W'(v_q) - OPA_W'(st2_q[axis_q]);
						opb_q   <= {1'b0, s2_gain_q};
						ret_q   <= ST_RUN_P2;
						state_q <= ST_WAIT;
					end else begin
						state_q <= ST_RUN_F1;
					end
				end
				ST_RUN_P2: begin
					st2_q[axis_q] <= st2_new;
					v_q           <= st2_new;
					state_q       <= ST_RUN_F1;
				end
				ST_RUN_F1: begin
					if (s1_en_q) begin
						opa_q   <= OPA_W'(v_q) - OPA_W'(st1_q[axis_q]);
						opb_q   <= {1'b0, s1_gain_q};
						ret_q   <= ST_RUN_P1;
						state_q <= ST_WAIT;
					end else begin
						state_q <= ST_RUN_OUT;
					end
				end
				ST_RUN_P1: begin
					st1_q[axis_q] <= st1_new;
					v_q           <= st1_new;
					state_q       <= ST_RUN_OUT;
				end
				ST_RUN_OUT: begin
					res_q[axis_q] <= v_q;
					if (axis_last) begin
						state_q <= ST_FIN;
					end else begin
						axis_q  <= axis_q + AX_W'(1);
						state_q <= ST_RUN_D;
					end
				end
				ST_WAIT: begin
					// product lands in prod_q during this cycle
					state_q <= ret_q;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: frees when the receiver takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			calib_out_q <= cal_flag_q;
			for (int a = 0; a < MAX_AXES; a++) begin
				rate_q[a] <= cal_flag_q ? '0 : res_ext[a];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign calibrating = calib_out_q;
	assign rate_x      = rate_q[0];
	assign rate_y      = rate_q[1];
	assign rate_z      = rate_q[2];

endmodule

// File: tb/gyro_bias_calibrate_and_lowpass_core_tb.sv
// Self-checking testbench for gyro_bias_calibrate_and_lowpass_core: motion rejection during
// bias calibration, bias capture, then scaling and the two PT1 stages under random settings.
// Depends on gbcl_pkg and the core RTL only.
module gyro_bias_calibrate_and_lowpass_core_tb;
	import gbcl_pkg::*;

	typedef longint unsigned u64_t;

	// one expected output transfer
	typedef struct {
		rate_t rate [3];
		logic  calibrating;
	} gyro_result_t;

	localparam int     FRAC_BITS      = 8;
	localparam longint RATE_MAX       = 64'sd16777215;
	localparam longint RATE_MIN       = -64'sd16777216;
	// longest quiet spell is the end of a calibration window (variance check plus three
	// serial divisions) or the receiver hold-off; allow many times the longer of the two
	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     RX_HOLD_CYCLES = 200;
	localparam int     SETTLE_CYCLES  = 64;
	localparam int     RANDOM_PHASES  = 7;
	localparam int     PHASE_SAMPLES  = 95;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	raw_t      raw_x     = '0;
	raw_t      raw_y     = '0;
	raw_t      raw_z     = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	rate_t     rate_x;
	rate_t     rate_y;
	rate_t     rate_z;
	logic      calibrating;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = REG_CALIB_LENGTH;
	cfg_data_t cfg_data  = '0;

	// shadow registers, at their reset values
	longint cal_len_reg = 10000;
	longint thresh_reg  = 48;
	longint scale_reg   = 4000;
	longint g1_reg      = 11226;
	longint g2_reg      = 18839;
	bit     en1_reg     = 1'b1;
	bit     en2_reg     = 1'b1;

	// predicted block state
	int     samples_to_go   = 10000;
	bit     bias_known      = 1'b0;
	longint bias_sum [3]    = '{default: 0};
	u64_t   bias_sqsum [3]  = '{default: 0};
	longint bias_offset [3] = '{default: 0};
	longint lp2_state [3]   = '{default: 0};
	longint lp1_state [3]   = '{default: 0};

	gyro_result_t pending_rates [$];

	// sensor bias per axis used once calibration is quiet
	int bias_raw [3] = '{-1234, 567, -20001};

	bit tx_calm     = 1'b0;
	bit rx_calm     = 1'b0;
	bit rx_hold_req = 1'b0;

	int samples_sent    = 0;
	int results_checked = 0;
	int register_writes = 0;
	int mismatch_count  = 0;
	int motion_restarts = 0;
	int quiet_cycles    = 0;

	gyro_bias_calibrate_and_lowpass_core #(
		.AXES         (3),
		.SAMPLE_BITS  (16),
		.FRACTION_BITS(FRAC_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.raw_z      (raw_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rate_x     (rate_x),
		.rate_y     (rate_y),
		.rate_z     (rate_z),
		.calibrating(calibrating),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------------------
	// Rate predictor
	// ---------------------------------------------------------------------------------

	// a zero length behaves as one
	function automatic int window_len();
		return (cal_len_reg == 0) ? 1 : int'(cal_len_reg);
	endfunction

	function automatic longint clamp_rate(input longint v);
		if (v > RATE_MAX) return RATE_MAX;
		if (v < RATE_MIN) return RATE_MIN;
		return v;
	endfunction

	// product with 16 fraction bits (Q47.16) back to integer, half rounds towards plus infinity
	function automatic longint q16_round(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint pt1_update(input longint state, input longint x,
			input longint gain);
		return clamp_rate(state + q16_round((x - state) * gain));
	endfunction

	// advances the predicted state by one sample and gives the result it should produce
	function automatic gyro_result_t next_rates(input raw_t sx, input raw_t sy, input raw_t sz);
		gyro_result_t res;
		longint       smp [3];
		longint       v;
		u64_t         mag;
		u64_t         sq_mean;
		u64_t         allow;
		u64_t         quo;
		int           n;
		bit           moved;
		smp[0] = sx;
		smp[1] = sy;
		smp[2] = sz;
		res.calibrating = 1'b0;
		for (int a = 0; a < 3; a++) res.rate[a] = '0;

		if (!bias_known) begin
			n = window_len();
			// fresh window: drop whatever the last attempt gathered
			if (samples_to_go >= n) begin
				samples_to_go = n;
				for (int a = 0; a < 3; a++) begin
					bias_sum[a]    = 0;
					bias_sqsum[a]  = 0;
					bias_offset[a] = 0;
				end
			end
			for (int a = 0; a < 3; a++) begin
				bias_sum[a]   += smp[a];
				bias_sqsum[a] += u64_t'(smp[a] * smp[a]);
			end
			if (samples_to_go <= 1) begin
				moved = 1'b0;
				// sum of squares minus sum^2/n against thr^2 * (n-1), i.e. std dev > thr
				if (thresh_reg != 0) begin
					for (int a = 0; a < 3; a++) begin
						mag     = (bias_sum[a] < 0) ? u64_t'(-bias_sum[a]) : u64_t'(bias_sum[a]);
						sq_mean = (mag * mag) / u64_t'(n);
						allow   = u64_t'(thresh_reg * thresh_reg) * u64_t'(n - 1);
						if (bias_sqsum[a] >= sq_mean && bias_sqsum[a] - sq_mean > allow)
							moved = 1'b1;
					end
				end
				if (moved) begin
					samples_to_go = n;
					motion_restarts++;
				end else begin
					// mean with fraction bits, half rounds away from zero
					for (int a = 0; a < 3; a++) begin
						mag = (bias_sum[a] < 0) ? u64_t'(-bias_sum[a]) : u64_t'(bias_sum[a]);
						quo = ((mag << FRAC_BITS) * 2 + u64_t'(n)) / (u64_t'(n) * 2);
						bias_offset[a] = clamp_rate((bias_sum[a] < 0) ? -longint'(quo)
								: longint'(quo));
					end
					bias_known    = 1'b1;
					samples_to_go = 0;
				end
			end else begin
				samples_to_go--;
			end
			res.calibrating = 1'b1;
			return res;
		end

		for (int a = 0; a < 3; a++) begin
			v = clamp_rate(q16_round(((smp[a] <<< FRAC_BITS) - bias_offset[a]) * scale_reg));
			if (en2_reg) begin
				lp2_state[a] = pt1_update(lp2_state[a], v, g2_reg);
				v = lp2_state[a];
			end
			if (en1_reg) begin
				lp1_state[a] = pt1_update(lp1_state[a], v, g1_reg);
				v = lp1_state[a];
			end
			res.rate[a] = rate_t'(v);
		end
		return res;
	endfunction

	// ---------------------------------------------------------------------------------
	// Channel drivers
	// ---------------------------------------------------------------------------------

	// one sample transfer; valid is left high so a back-to-back sample keeps it up
	task automatic send_sample(input raw_t sx, input raw_t sy, input raw_t sz);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_x    <= sx;
		raw_y    <= sy;
		raw_z    <= sz;
		do @(posedge clk); while (!in_ready);
		pending_rates.push_back(next_rates(sx, sy, sz));
		samples_sent++;
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_rates.size() != 0);
	endtask

	task automatic write_register(input cfg_idx_t idx, input cfg_data_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CALIB_LENGTH: begin
				cal_len_reg = value;
				// only an unfinished calibration restarts
				if (!bias_known) samples_to_go = window_len();
			end
			REG_MOTION_THRESH: thresh_reg = value[THR_W-1:0];
			REG_RATE_SCALE:    scale_reg  = value;
			REG_S1_GAIN:       g1_reg     = value;
			REG_S1_ENABLE:     en1_reg    = value[0];
			REG_S2_GAIN:       g2_reg     = value;
			REG_S2_ENABLE:     en2_reg    = value[0];
			default: ;
		endcase
		register_writes++;
	endtask

	task automatic configure_calibration(input int unsigned len, input int unsigned thr);
		wait_drained();
		write_register(REG_CALIB_LENGTH, cfg_data_t'(len));
		write_register(REG_MOTION_THRESH, cfg_data_t'(thr));
		cfg_valid <= 1'b0;
	endtask

	task automatic configure_filter(input int unsigned scale, input int unsigned g1,
			input bit en1, input int unsigned g2, input bit en2);
		wait_drained();
		write_register(REG_RATE_SCALE, cfg_data_t'(scale));
		write_register(REG_S1_GAIN, cfg_data_t'(g1));
		write_register(REG_S1_ENABLE, cfg_data_t'(en1));
		write_register(REG_S2_GAIN, cfg_data_t'(g2));
		write_register(REG_S2_ENABLE, cfg_data_t'(en2));
		cfg_valid <= 1'b0;
	endtask

	// gains and scale: mostly random, with both ends of the range often enough
	function automatic int unsigned pick_coeff();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 65535;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
				results_checked);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------------------------
	// Result side: random back-pressure, one long hold-off on request
	// ---------------------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold_req) begin
				// long hold so the output register and the sequencer both fill up
				rx_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			stall = rx_calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// every output transfer is matched against the oldest prediction
	always @(posedge clk) begin : check_results
		gyro_result_t want;
		rate_t        got_rate [3];
		if (arst_n && out_valid && out_ready) begin
			if (pending_rates.size() == 0) begin
				report_mismatch("result with no sample outstanding, calibrating",
						calibrating, 0);
			end else begin
				want = pending_rates.pop_front();
				got_rate[0] = rate_x;
				got_rate[1] = rate_y;
				got_rate[2] = rate_z;
				for (int a = 0; a < 3; a++) begin
					if (got_rate[a] !== want.rate[a])
						report_mismatch($sformatf("rate axis %0d", a), got_rate[a],
								want.rate[a]);
				end
				if (calibrating !== want.calibrating)
					report_mismatch("calibrating", calibrating, want.calibrating);
			end
			results_checked++;
		end
	end

	// hang detection: any transfer on any channel counts as progress
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------

	// windows with clear motion, and motion just above the limit on a single axis
	task automatic test_restart_on_motion();
		configure_calibration(4, 1);
		send_sample(raw_t'(32767), raw_t'(-32768), raw_t'(0));
		send_sample(raw_t'(-32768), raw_t'(32767), raw_t'(-1));
		send_sample(raw_t'(0), raw_t'(1), raw_t'(-32768));
		send_sample(raw_t'(-1), raw_t'(0), raw_t'(32767));
		// x: variance term 2t^2+2t+1 against allowance 2t^2
		configure_calibration(3, 100);
		send_sample(raw_t'(-100), raw_t'(5), raw_t'(5));
		send_sample(raw_t'(0), raw_t'(5), raw_t'(5));
		send_sample(raw_t'(101), raw_t'(5), raw_t'(5));
		// same on z, others steady
		send_sample(raw_t'(7), raw_t'(7), raw_t'(-100));
		send_sample(raw_t'(7), raw_t'(7), raw_t'(0));
		send_sample(raw_t'(7), raw_t'(7), raw_t'(101));
		// largest threshold still loses to full-scale swings
		configure_calibration(2, 255);
		send_sample(raw_t'(32767), raw_t'(32767), raw_t'(32767));
		send_sample(raw_t'(-32768), raw_t'(-32768), raw_t'(-32768));
	endtask

	// short windows of full-range noise under random thresholds
	task automatic test_random_restarts();
		int unsigned len;
		repeat (10) begin
			len = $urandom_range(2, 9);
			configure_calibration(len, $urandom_range(1, 255));
			repeat (len) send_sample(raw_t'($urandom), raw_t'($urandom), raw_t'($urandom));
		end
	endtask

	// length rewritten part-way restarts the window; the motion check is off, so a noisy
	// 512-sample window must be taken; odd x sum puts the x offset on a half
	task automatic test_bias_capture();
		int xsum;
		int smp [3];
		xsum = 0;
		configure_calibration(520, 0);
		repeat (8) send_sample(raw_t'($urandom), raw_t'($urandom), raw_t'($urandom));
		configure_calibration(512, 0);
		for (int i = 0; i < 512; i++) begin
			for (int a = 0; a < 3; a++)
				smp[a] = bias_raw[a] + int'($urandom_range(0, 3000)) - 1500;
			if (i == 511 && ((xsum + smp[0]) & 1) == 0) smp[0] += 1;
			xsum += smp[0];
			send_sample(raw_t'(smp[0]), raw_t'(smp[1]), raw_t'(smp[2]));
		end
	endtask

	// both stages bypassed at full scale: offset removal and scaling alone
	task automatic test_raw_passthrough();
		configure_filter(65535, 0, 1'b0, 0, 1'b0);
		send_sample(raw_t'(32767), raw_t'(-32768), raw_t'(0));
		send_sample(raw_t'(-32768), raw_t'(32767), raw_t'(-1));
		send_sample(raw_t'(0), raw_t'(0), raw_t'(0));
		send_sample(raw_t'(-1234), raw_t'(567), raw_t'(-20001));
	endtask

	// gain near one tracks, gain zero holds, scale zero decays towards zero
	task automatic test_filter_gain_extremes();
		configure_filter(4000, 65535, 1'b1, 65535, 1'b1);
		send_sample(raw_t'(32767), raw_t'(-32768), raw_t'(100));
		send_sample(raw_t'(-32768), raw_t'(32767), raw_t'(-100));
		send_sample(raw_t'(1000), raw_t'(-1000), raw_t'(0));
		configure_filter(4000, 0, 1'b1, 0, 1'b1);
		send_sample(raw_t'(32767), raw_t'(32767), raw_t'(32767));
		send_sample(raw_t'(-32768), raw_t'(-32768), raw_t'(-32768));
		configure_filter(0, 65535, 1'b1, 65535, 1'b1);
		send_sample(raw_t'(32767), raw_t'(-32768), raw_t'(0));
		send_sample(raw_t'(12345), raw_t'(-12345), raw_t'(1));
	endtask

	// one stage on at a time; the bypassed stage keeps its state
	task automatic test_single_stage();
		configure_filter(4000, 11226, 1'b1, 18839, 1'b0);
		send_sample(raw_t'(20000), raw_t'(-5000), raw_t'(-30000));
		send_sample(raw_t'(20000), raw_t'(-5000), raw_t'(-30000));
		send_sample(raw_t'(-20000), raw_t'(5000), raw_t'(30000));
		configure_filter(4000, 11226, 1'b0, 18839, 1'b1);
		send_sample(raw_t'(20000), raw_t'(-5000), raw_t'(-30000));
		send_sample(raw_t'(20000), raw_t'(-5000), raw_t'(-30000));
		send_sample(raw_t'(-20000), raw_t'(5000), raw_t'(30000));
	endtask

	// random settings per phase; calibration registers are rewritten too and must be ignored
	task automatic test_random_filtering();
		raw_t last [3]   = '{default: '0};
		raw_t smp [3];
		raw_t corner [4] = '{raw_t'(32767), raw_t'(-32768), raw_t'(0), raw_t'(-1)};
		int   kind;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					configure_calibration(0, 0);
					configure_filter(4000, 11226, 1'b1, 18839, 1'b1);
				end
				1: begin
					configure_calibration(65535, 255);
					configure_filter(pick_coeff(), pick_coeff(), 1'b1, pick_coeff(), 1'b1);
				end
				default: begin
					configure_calibration($urandom_range(0, 65535), $urandom_range(0, 255));
					configure_filter(pick_coeff(), pick_coeff(), $urandom_range(0, 1),
							pick_coeff(), $urandom_range(0, 1));
				end
			endcase
			// idle-free stretches on one side or the other
			tx_calm = (p % 3 == 1);
			rx_calm = (p % 3 == 2);
			if (p == 3) rx_hold_req = 1'b1;
			repeat (PHASE_SAMPLES) begin
				for (int a = 0; a < 3; a++) begin
					kind = $urandom_range(0, 9);
					if (kind < 5)
						smp[a] = raw_t'(bias_raw[a] + int'($urandom_range(0, 400)) - 200);
					else if (kind < 8)
						smp[a] = raw_t'($urandom);
					else if (kind == 8)
						smp[a] = corner[$urandom_range(0, 3)];
					else
						smp[a] = last[a];
				end
				last = smp;
				send_sample(smp[0], smp[1], smp[2]);
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// ---------------------------------------------------------------------------------
	// Sequence: calibration is only ever completed once per reset, so the motion tests come
	// first, then the bias capture, then everything downstream of the offset
	// ---------------------------------------------------------------------------------
	initial begin : test_sequence
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_restart_on_motion();
		test_random_restarts();
		test_bias_capture();
		test_raw_passthrough();
		test_filter_gain_extremes();
		test_single_stage();
		test_random_filtering();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d samples, %0d calibration windows rejected for motion, %0d",
				samples_sent, motion_restarts, register_writes);
		$display("register writes; %0d results checked, %0d mismatches.", results_checked,
				mismatch_count);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
